// ===== rtl/tsq_pkg.sv =====
// Shared types, constants and tables for the three-voice tone sequencer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tsq_pkg;

   // Step queue geometry. The counters carry one extra bit so that full
   // and empty are told apart.
   localparam int QUEUE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;

   localparam int VOICES   = 3;
   localparam int VIDX_W   = 2;
   localparam int FREQ_W   = 19;
   localparam int LEVEL_W  = 4;
   localparam int DUR_W    = 16;
   localparam int AMP_W    = 14;
   localparam int PHASE_W  = 32;
   localparam int SAMPLE_W = 16;
   localparam int QSTEP_W  = 9;

   localparam int TICKS_PER_MSEC = 48;
   localparam int TICK_RATE_HZ   = TICKS_PER_MSEC * 1000;
   localparam int HALF_RATE      = TICK_RATE_HZ / 2;
   localparam int REM_W          = DUR_W + $clog2(TICKS_PER_MSEC + 1);

   // Increment = round(f * 2^PHASE_FRAC / TICK_RATE_HZ). The quotient is
   // first estimated with a truncated reciprocal, then corrected.
   localparam int PHASE_FRAC  = 28;
   localparam int RECIP_SHIFT = FREQ_W;
   localparam int MUL_W       = 32;
   localparam int ALU_W       = 2 * MUL_W;
   localparam logic [MUL_W-1:0] RECIP =
      MUL_W'((64'd1 << (PHASE_FRAC + RECIP_SHIFT)) / 64'(TICK_RATE_HZ));

   // The mix of three voices fits in one bit more than a sample.
   localparam int SUM_W = SAMPLE_W + 1;

   // Amplitude = round(32767 * level / 45).
   localparam logic [AMP_W-1:0] AMP_TABLE [16] = '{
      14'd0,    14'd728,  14'd1456, 14'd2184, 14'd2913, 14'd3641,
      14'd4369, 14'd5097, 14'd5825, 14'd6553, 14'd7282, 14'd8010,
      14'd8738, 14'd9466, 14'd10194, 14'd10922
   };

   // Request codes.
   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_STOP    = 2'd1;
   localparam logic [1:0] REQ_TICK    = 2'd2;

   // Shared arithmetic unit operations.
   localparam logic [1:0] ALU_ADD = 2'd0;
   localparam logic [1:0] ALU_SUB = 2'd1;
   localparam logic [1:0] ALU_MUL = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [FREQ_W-1:0]  voice0_frequency;
      logic [FREQ_W-1:0]  voice1_frequency;
      logic [FREQ_W-1:0]  voice2_frequency;
      logic [LEVEL_W-1:0] voice0_level;
      logic [LEVEL_W-1:0] voice1_level;
      logic [LEVEL_W-1:0] voice2_level;
      logic [DUR_W-1:0]   step_length;
   } tone_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_value;
      logic                       step_accepted;
      logic                       is_playing;
      logic [QSTEP_W-1:0]         queued_steps;
   } tone_rsp_type;

   typedef struct packed {
      logic [VOICES-1:0][FREQ_W-1:0]  freq;
      logic [VOICES-1:0][LEVEL_W-1:0] level;
      logic [DUR_W-1:0]               duration;
   } step_entry_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/tsq_step_ram.sv =====
// Step queue storage: one write port and one registered read port.
// Depends on tsq_pkg for the entry type and the queue depth.
`default_nettype none

module tsq_step_ram
   import tsq_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire step_entry_type wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output step_entry_type      rd_data
);

   step_entry_type mem [QUEUE_DEPTH];
   step_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tsq_alu.sv =====
// Shared arithmetic unit: one multiplier and one adder/subtractor with a
// registered result. Depends on tsq_pkg for the command struct and codes.
`default_nettype none

module tsq_alu
   import tsq_pkg::*;
(
   input  wire logic        clock,
   input  wire alu_cmd_type cmd,
   output logic [ALU_W-1:0] res
);

   logic [ALU_W-1:0] res_ff;
   logic [ALU_W-1:0] res_in;
   logic [MUL_W-1:0] mul_a;
   logic [MUL_W-1:0] mul_b;

   assign mul_a = cmd.a[MUL_W-1:0];
   assign mul_b = cmd.b[MUL_W-1:0];

   always_comb begin
      unique case (cmd.op)
         ALU_ADD: res_in = cmd.a + cmd.b;
         ALU_SUB: res_in = cmd.a - cmd.b;
         ALU_MUL: res_in = ALU_W'(mul_a) * ALU_W'(mul_b);
         default: res_in = cmd.a;
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// ===== rtl/queued_three_voice_square_tone_sequencer.sv =====
// Top level of the three-voice square tone sequencer: sequencer, voice state
// and queue counters. Depends on tsq_pkg, tsq_step_ram and tsq_alu.
//
// A transaction is taken when start is high and busy is low; its result shows
// on rsp_data for the single cycle in which rsp_strobe is high, and the
// receiver must take it then. Enqueue, stop and unused codes keep busy high
// through the execute and done states only. A tick that continues the current
// step mixes and saturates before the done state; one that loads the next step
// from the queue first works out each voice's phase increment on the one
// shared multiplier/adder (reciprocal estimate, back-multiply, remainder, up
// to two corrections), and the three voices are then mixed on that same unit
// one voice per cycle. The result strobe is high in the first cycle in which
// busy is low again, and a new transaction may start in that cycle.
`default_nettype none

module queued_three_voice_square_tone_sequencer
   import tsq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire tone_req_type req_data,
   output logic              busy,
   output logic              rsp_strobe,
   output tone_rsp_type      rsp_data
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_EXEC   = 4'd1;
   localparam logic [3:0] ST_L_MUL1 = 4'd2;
   localparam logic [3:0] ST_L_MUL2 = 4'd3;
   localparam logic [3:0] ST_L_SUB  = 4'd4;
   localparam logic [3:0] ST_L_CORR = 4'd5;
   localparam logic [3:0] ST_L_FIN  = 4'd6;
   localparam logic [3:0] ST_MIX    = 4'd7;
   localparam logic [3:0] ST_SAT    = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;

   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(32768);

   logic [3:0]        state_ff, state_in;
   logic [VIDX_W-1:0] vidx_ff, vidx_in;
   logic [CNT_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [PHASE_W-1:0] inc_ff [VOICES];
   logic [PHASE_W-1:0] inc_in [VOICES];
   logic [AMP_W-1:0]   amp_ff [VOICES];
   logic [AMP_W-1:0]   amp_in [VOICES];
   logic [PHASE_W-1:0] phase_ff [VOICES];
   logic [PHASE_W-1:0] phase_in [VOICES];
   logic [PHASE_W-1:0] q_ff, q_in;
   tone_req_type       req_ff, req_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic               accepted_ff, accepted_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   tone_rsp_type       rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]   occupancy;
   logic               wr_en;
   step_entry_type     wr_entry;
   step_entry_type     rd_entry;
   alu_cmd_type        alu_cmd;
   logic [ALU_W-1:0]   alu_res;
   logic [FREQ_W-1:0]  load_freq;
   logic signed [SUM_W-1:0] mix_sum;

   tsq_step_ram u_step_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ff[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_ff[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   tsq_alu u_alu (
      .clock (clock),
      .cmd   (alu_cmd),
      .res   (alu_res)
   );

   // Both counters wrap at twice the depth, so the difference is the fill.
   assign occupancy = wr_ff - rd_ff;
   assign load_freq = rd_entry.freq[vidx_ff];
   assign mix_sum   = signed'(alu_res[SUM_W-1:0]);

   assign wr_entry.freq[0]  = req_ff.voice0_frequency;
   assign wr_entry.freq[1]  = req_ff.voice1_frequency;
   assign wr_entry.freq[2]  = req_ff.voice2_frequency;
   assign wr_entry.level[0] = req_ff.voice0_level;
   assign wr_entry.level[1] = req_ff.voice1_level;
   assign wr_entry.level[2] = req_ff.voice2_level;
   assign wr_entry.duration = req_ff.step_length;

   always_comb begin
      state_in      = state_ff;
      vidx_in       = vidx_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      rem_in        = rem_ff;
      inc_in        = inc_ff;
      amp_in        = amp_ff;
      phase_in      = phase_ff;
      q_in          = q_ff;
      req_in        = req_ff;
      sample_in     = sample_ff;
      accepted_in   = accepted_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      alu_cmd.op    = ALU_ADD;
      alu_cmd.a     = '0;
      alu_cmd.b     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in      = req_data;
               sample_in   = '0;
               accepted_in = 1'b0;
               state_in    = ST_EXEC;
            end
         end

         ST_EXEC: begin
            vidx_in  = '0;
            state_in = ST_DONE;
            unique case (req_ff.req_type)
               REQ_ENQUEUE: begin
                  if ((req_ff.step_length != '0) && (occupancy < CNT_W'(QUEUE_DEPTH))) begin
                     wr_en       = 1'b1;
                     wr_in       = wr_ff + 1'b1;
                     accepted_in = 1'b1;
                  end
               end
               REQ_STOP: begin
                  rd_in  = wr_ff;
                  rem_in = '0;
                  for (int v = 0; v < VOICES; v++) begin
                     inc_in[v]   = '0;
                     phase_in[v] = '0;
                  end
               end
               REQ_TICK: begin
                  if (rem_ff != '0) begin
                     state_in = ST_MIX;
                  end else if (occupancy != '0) begin
                     state_in = ST_L_MUL1;
                  end else begin
                     for (int v = 0; v < VOICES; v++) begin
                        inc_in[v]   = '0;
                        phase_in[v] = '0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         // Quotient estimate from the truncated reciprocal; it is low by
         // at most two.
         ST_L_MUL1: begin
            alu_cmd.op = ALU_MUL;
            alu_cmd.a  = ALU_W'(load_freq);
            alu_cmd.b  = ALU_W'(RECIP);
            state_in   = ST_L_MUL2;
         end

         ST_L_MUL2: begin
            q_in       = alu_res[RECIP_SHIFT +: PHASE_W];
            alu_cmd.op = ALU_MUL;
            alu_cmd.a  = ALU_W'(alu_res[RECIP_SHIFT +: PHASE_W]);
            alu_cmd.b  = ALU_W'(TICK_RATE_HZ);
            state_in   = ST_L_SUB;
         end

         // The rounding half is below the frequency's shift, so OR adds it.
         ST_L_SUB: begin
            alu_cmd.op = ALU_SUB;
            alu_cmd.a  = (ALU_W'(load_freq) << PHASE_FRAC) | ALU_W'(HALF_RATE);
            alu_cmd.b  = alu_res;
            state_in   = ST_L_CORR;
         end

         ST_L_CORR: begin
            if (alu_res >= ALU_W'(TICK_RATE_HZ)) begin
               alu_cmd.op = ALU_SUB;
               alu_cmd.a  = alu_res;
               alu_cmd.b  = ALU_W'(TICK_RATE_HZ);
               q_in       = q_ff + 1'b1;
            end else begin
               inc_in[vidx_ff] = q_ff;
               amp_in[vidx_ff] = AMP_TABLE[rd_entry.level[vidx_ff]];
               if (load_freq == '0) begin
                  phase_in[vidx_ff] = '0;
               end
               if (vidx_ff == VIDX_W'(VOICES - 1)) begin
                  state_in = ST_L_FIN;
               end else begin
                  vidx_in  = vidx_ff + 1'b1;
                  state_in = ST_L_MUL1;
               end
            end
         end

         ST_L_FIN: begin
            rem_in   = REM_W'(rd_entry.duration) * REM_W'(TICKS_PER_MSEC);
            rd_in    = rd_ff + 1'b1;
            vidx_in  = '0;
            state_in = ST_MIX;
         end

         // One voice per cycle: the running sum stays in the unit's register.
         ST_MIX: begin
            alu_cmd.a = (vidx_ff == '0) ? '0 : alu_res;
            if (inc_ff[vidx_ff] != '0) begin
               alu_cmd.op = phase_ff[vidx_ff][PHASE_W-1] ? ALU_SUB : ALU_ADD;
               alu_cmd.b  = ALU_W'(amp_ff[vidx_ff]);
               phase_in[vidx_ff] = phase_ff[vidx_ff] + inc_ff[vidx_ff];
            end
            if (vidx_ff == VIDX_W'(VOICES - 1)) begin
               state_in = ST_SAT;
            end else begin
               vidx_in = vidx_ff + 1'b1;
            end
         end

         ST_SAT: begin
            if (mix_sum > SUM_MAX) begin
               sample_in = SAMPLE_W'(SUM_MAX);
            end else if (mix_sum < SUM_MIN) begin
               sample_in = SAMPLE_W'(SUM_MIN);
            end else begin
               sample_in = mix_sum[SAMPLE_W-1:0];
            end
            if (rem_ff != '0) begin
               rem_in = rem_ff - 1'b1;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            rsp_strobe_in              = 1'b1;
            rsp_data_in.sample_value   = sample_ff;
            rsp_data_in.step_accepted  = accepted_ff;
            rsp_data_in.is_playing     = (occupancy != '0) || (rem_ff != '0);
            rsp_data_in.queued_steps   = QSTEP_W'(occupancy);
            state_in                   = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vidx_ff       <= '0;
         rd_ff         <= '0;
         wr_ff         <= '0;
         rem_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int v = 0; v < VOICES; v++) begin
            inc_ff[v]   <= '0;
            amp_ff[v]   <= '0;
            phase_ff[v] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         vidx_ff       <= vidx_in;
         rd_ff         <= rd_in;
         wr_ff         <= wr_in;
         rem_ff        <= rem_in;
         rsp_strobe_ff <= rsp_strobe_in;
         inc_ff        <= inc_in;
         amp_ff        <= amp_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      req_ff      <= req_in;
      sample_ff   <= sample_in;
      accepted_ff <= accepted_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tsq_checker.sv =====
// Port-level checks for the tone sequencer, bound to its top level.
// Depends on tsq_pkg and on the top level's port names.
`default_nettype none

module tsq_checker
   import tsq_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire tone_req_type req_data,
   input wire logic         busy,
   input wire logic         rsp_strobe,
   input wire tone_rsp_type rsp_data
);

   // A taken transaction makes the block busy in the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a transaction was taken");

   // A result only appears right after the block has been busy.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result strobe without a preceding busy period");

   // The strobe lasts one cycle per transaction.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // The queue never reports more than its depth, and queued steps mean playing.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.queued_steps <= QSTEP_W'(QUEUE_DEPTH)) &&
                      ((rsp_data.queued_steps == '0) || rsp_data.is_playing)))
      else $error("queue fill out of range or inconsistent with playing status");

endmodule

bind queued_three_voice_square_tone_sequencer tsq_checker u_tsq_checker (.*);

`default_nettype wire
